### hdl/srpt_pkg.sv
package srpt_pkg;

  localparam int QueueDepth = 16;
  localparam int CountW     = $clog2(QueueDepth + 1);
  localparam int RemW       = 32;
  localparam int IdW        = 32;
  localparam int GrantW     = 48;
  localparam logic [31:0] BandwidthReset = 32'd1024;

  typedef enum logic [2:0] {
    KIND_ACCEPTED  = 3'd0,
    KIND_EMPTY     = 3'd1,
    KIND_FULL      = 3'd2,
    KIND_COMPLETED = 3'd3,
    KIND_DONE      = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_INSERT  = 2'd1,
    CELL_POP     = 2'd2,
    CELL_SETHEAD = 2'd3
  } cell_op_e;

  // Operation code of the input item.
  localparam logic OP_ADD     = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

endpackage

### hdl/srpt_cell.sv
// One slot of the sorted queue. It compares its own remaining count with the
// broadcast size and takes a value from the broadcast bus or a neighbor.
module srpt_cell (
  input  logic                      clk_i,
  input  srpt_pkg::cell_op_e        op_i,
  input  logic                      occ_i,
  input  logic [srpt_pkg::RemW-1:0] new_rem_i,
  input  logic [srpt_pkg::IdW-1:0]  new_id_i,
  input  logic                      less_left_i,
  input  logic [srpt_pkg::RemW-1:0] left_rem_i,
  input  logic [srpt_pkg::IdW-1:0]  left_id_i,
  input  logic [srpt_pkg::RemW-1:0] right_rem_i,
  input  logic [srpt_pkg::IdW-1:0]  right_id_i,
  output logic [srpt_pkg::RemW-1:0] rem_o,
  output logic [srpt_pkg::IdW-1:0]  id_o,
  output logic                      less_o
);

  logic [srpt_pkg::RemW-1:0] rem_q, rem_d;
  logic [srpt_pkg::IdW-1:0]  id_q, id_d;
  logic                      less;

  // Occupied slots holding fewer bytes than the new size stay ahead of it.
  assign less = occ_i && (rem_q < new_rem_i);

  always_comb begin
    rem_d = rem_q;
    id_d  = id_q;
    case (op_i)
      srpt_pkg::CELL_INSERT: begin
        if (!less) begin
          if (less_left_i) begin
            rem_d = new_rem_i;
            id_d  = new_id_i;
          end else begin
            rem_d = left_rem_i;
            id_d  = left_id_i;
          end
        end
      end
      srpt_pkg::CELL_POP: begin
        rem_d = right_rem_i;
        id_d  = right_id_i;
      end
      srpt_pkg::CELL_SETHEAD: begin
        rem_d = new_rem_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    id_q  <= id_d;
  end

  assign rem_o  = rem_q;
  assign id_o   = id_q;
  assign less_o = less;

endmodule

### hdl/download_srpt_scheduler_top.sv
// Shortest-remaining-first transfer scheduler.
// Input items arrive on the command channel: an item is taken at a rising
// edge where start_i is high and busy_o is low. An add item (operation 0)
// places a transfer of size_i bytes into a queue of 16 slots kept in
// ascending order of remaining bytes; the newer request wins a tie. An
// advance item (operation 1) grants seconds_i times the bandwidth register
// in bytes, spent from the head of the queue.
// Results appear for exactly one cycle with result_strobe_o high; the
// receiver cannot stall, so no result is ever held back. An add item gives
// one result in the cycle after it is taken and busy_o stays low, so add
// items may follow every cycle. An advance item forms the 16x32 grant
// product in the MUL state, then in the DRAIN state reports each completed
// transfer, reduces the head if it is only partly served, and gives the done
// result; busy_o stays high meanwhile. The drain walks the head of the
// slot chain, one pop per cycle, and that sets the rate.
// The bandwidth register is written over the cfg channel, which is always
// ready. Reset empties the queue, clears the id counter and sets bandwidth
// to 1024; slot contents are not cleared, since empty slots are never read.
module download_srpt_scheduler_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        operation_i,
  input  logic [31:0] size_i,
  input  logic [15:0] seconds_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_bandwidth_i,
  output logic        result_strobe_o,
  output logic [2:0]  kind_o,
  output logic [31:0] download_id_o,
  output logic        last_o
);

  localparam int QD = srpt_pkg::QueueDepth;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MUL   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [srpt_pkg::CountW-1:0] count_q, count_d;
  logic [31:0]                 next_id_q, next_id_d;
  logic [31:0]                 bandwidth_q;
  logic [15:0]                 seconds_q;
  logic [srpt_pkg::GrantW-1:0] grant_q, grant_d;

  logic                        strobe_q, strobe_d;
  srpt_pkg::kind_e             kind_q, kind_d;
  logic [31:0]                 id_q, id_d;
  logic                        last_q, last_d;

  srpt_pkg::cell_op_e          cell_op [QD];
  logic [srpt_pkg::RemW-1:0]   rem_w [QD];
  logic [srpt_pkg::IdW-1:0]    id_w [QD];
  logic [QD-1:0]               less_w;
  logic [QD-1:0]               occ_w;
  logic [srpt_pkg::RemW-1:0]   bus_rem;

  logic                        accept;
  logic                        full;
  logic [srpt_pkg::GrantW-1:0] head_rem;
  logic [srpt_pkg::GrantW-1:0] head_left;
  logic                        covered;
  logic                        do_insert;
  logic                        do_pop;
  logic                        do_sethead;

  assign accept   = start_i && !busy_o;
  assign full     = (count_q >= srpt_pkg::CountW'(QD));
  assign head_rem = {{(srpt_pkg::GrantW - srpt_pkg::RemW){1'b0}}, rem_w[0]};
  assign head_left = head_rem - grant_q;
  assign covered  = (grant_q >= head_rem);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    next_id_d  = next_id_q;
    grant_d    = grant_q;
    strobe_d   = 1'b0;
    kind_d     = kind_q;
    id_d       = id_q;
    last_d     = last_q;
    do_insert  = 1'b0;
    do_pop     = 1'b0;
    do_sethead = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (operation_i == srpt_pkg::OP_ADD) begin
            next_id_d = next_id_q + 32'd1;
            strobe_d  = 1'b1;
            last_d    = 1'b1;
            id_d      = 32'd0;
            if (size_i == 32'd0) begin
              kind_d = srpt_pkg::KIND_EMPTY;
            end else if (full) begin
              kind_d = srpt_pkg::KIND_FULL;
            end else begin
              kind_d    = srpt_pkg::KIND_ACCEPTED;
              id_d      = next_id_q;
              do_insert = 1'b1;
              count_d   = count_q + srpt_pkg::CountW'(1);
            end
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        grant_d = srpt_pkg::GrantW'(seconds_q) * srpt_pkg::GrantW'(bandwidth_q);
        state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (grant_q == '0 || count_q == '0) begin
          strobe_d = 1'b1;
          kind_d   = srpt_pkg::KIND_DONE;
          id_d     = 32'd0;
          last_d   = 1'b1;
          state_d  = ST_IDLE;
        end else if (covered) begin
          // The head is fully served: report it and shift the chain up.
          strobe_d = 1'b1;
          kind_d   = srpt_pkg::KIND_COMPLETED;
          id_d     = id_w[0];
          last_d   = 1'b0;
          grant_d  = grant_q - head_rem;
          do_pop   = 1'b1;
          count_d  = count_q - srpt_pkg::CountW'(1);
        end else begin
          do_sethead = 1'b1;
          grant_d    = '0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The broadcast bus carries the new size on insert and the reduced head
  // count on a partial grant.
  assign bus_rem = do_sethead ? head_left[srpt_pkg::RemW-1:0] : size_i;

  always_comb begin
    for (int i = 0; i < QD; i++) begin
      occ_w[i] = (srpt_pkg::CountW'(i) < count_q);
      if (do_insert) begin
        cell_op[i] = srpt_pkg::CELL_INSERT;
      end else if (do_pop) begin
        cell_op[i] = srpt_pkg::CELL_POP;
      end else if (do_sethead && i == 0) begin
        cell_op[i] = srpt_pkg::CELL_SETHEAD;
      end else begin
        cell_op[i] = srpt_pkg::CELL_HOLD;
      end
    end
  end

  for (genvar g = 0; g < QD; g++) begin : g_cell
    logic                      less_left;
    logic [srpt_pkg::RemW-1:0] left_rem, right_rem;
    logic [srpt_pkg::IdW-1:0]  left_id, right_id;

    if (g == 0) begin : g_first
      assign less_left = 1'b1;
      assign left_rem  = rem_w[g];
      assign left_id   = id_w[g];
    end else begin : g_mid
      assign less_left = less_w[g-1];
      assign left_rem  = rem_w[g-1];
      assign left_id   = id_w[g-1];
    end

    if (g == QD - 1) begin : g_last
      assign right_rem = rem_w[g];
      assign right_id  = id_w[g];
    end else begin : g_inner
      assign right_rem = rem_w[g+1];
      assign right_id  = id_w[g+1];
    end

    srpt_cell u_cell (
      .clk_i       (clk_i),
      .op_i        (cell_op[g]),
      .occ_i       (occ_w[g]),
      .new_rem_i   (bus_rem),
      .new_id_i    (next_id_q),
      .less_left_i (less_left),
      .left_rem_i  (left_rem),
      .left_id_i   (left_id),
      .right_rem_i (right_rem),
      .right_id_i  (right_id),
      .rem_o       (rem_w[g]),
      .id_o        (id_w[g]),
      .less_o      (less_w[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      next_id_q   <= '0;
      bandwidth_q <= srpt_pkg::BandwidthReset;
      strobe_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      next_id_q <= next_id_d;
      strobe_q  <= strobe_d;
      if (cfg_valid_i && cfg_ready_o) begin
        bandwidth_q <= cfg_bandwidth_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grant_q <= grant_d;
    kind_q  <= kind_d;
    id_q    <= id_d;
    last_q  <= last_d;
    if (accept) begin
      seconds_q <= seconds_i;
    end
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign result_strobe_o = strobe_q;
  assign kind_o          = kind_q;
  assign download_id_o   = id_q;
  assign last_o          = last_q;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import srpt_pkg::*;

  // Cycles with no item moving on any channel before the run is declared hung.
  localparam int WatchdogLimit = 1000;
  // Quiet cycles allowed after the last result before a register write; DrainCycles serves the end.
  localparam int SettleCycles  = 6;
  localparam int DrainCycles   = 24;
  localparam int ItemsPerLeg   = 58;

  // One result as the scheduler reports it.
  typedef struct packed {
    kind_e       kind;
    logic [31:0] id;
    logic        last;
  } sched_result_t;

  // Shadow copy of the transfer queue. Each accepted item is applied to it, and the
  // results that the item must cause are queued in order, oldest first.
  class srpt_scoreboard;
    logic [RemW-1:0] remaining[QueueDepth];
    logic [IdW-1:0]  ids[QueueDepth];
    int unsigned     depth;
    logic [IdW-1:0]  id_counter;
    logic [31:0]     bandwidth;
    sched_result_t   awaited[$];
    int unsigned     mismatches;
    int unsigned     items;
    int unsigned     results_seen;
    int unsigned     completions;
    int unsigned     full_rejects;
    int unsigned     empty_rejects;

    function new();
      depth         = 0;
      id_counter    = '0;
      bandwidth     = BandwidthReset;
      mismatches    = 0;
      items         = 0;
      results_seen  = 0;
      completions   = 0;
      full_rejects  = 0;
      empty_rejects = 0;
    endfunction

    function void push_result(kind_e kind, logic [31:0] id, logic last);
      sched_result_t r;
      r.kind = kind;
      r.id   = id;
      r.last = last;
      awaited.push_back(r);
    endfunction

    // Applies one accepted input item to the shadow queue.
    function void note_item(logic op, logic [31:0] size, logic [15:0] seconds);
      logic [GrantW-1:0] grant;
      logic [IdW-1:0]    id;
      int unsigned       pos;
      items++;
      if (op == OP_ADD) begin
        // Every add takes an id, even one that is turned away.
        id = id_counter;
        id_counter = id_counter + 1'b1;
        if (size == '0) begin
          empty_rejects++;
          push_result(KIND_EMPTY, '0, 1'b1);
        end else if (depth >= QueueDepth) begin
          full_rejects++;
          push_result(KIND_FULL, '0, 1'b1);
        end else begin
          // The new entry goes ahead of every entry that is equal or larger.
          pos = 0;
          while (pos < depth && remaining[pos] < size) pos++;
          for (int unsigned i = depth; i > pos; i--) begin
            remaining[i] = remaining[i-1];
            ids[i]       = ids[i-1];
          end
          remaining[pos] = size;
          ids[pos]       = id;
          depth++;
          push_result(KIND_ACCEPTED, id, 1'b1);
        end
      end else begin
        grant = GrantW'(seconds) * GrantW'(bandwidth);
        while (grant != '0 && depth > 0) begin
          if (grant < GrantW'(remaining[0])) begin
            remaining[0] = remaining[0] - grant[RemW-1:0];
            grant = '0;
          end else begin
            grant = grant - GrantW'(remaining[0]);
            completions++;
            push_result(KIND_COMPLETED, ids[0], 1'b0);
            for (int unsigned i = 1; i < depth; i++) begin
              remaining[i-1] = remaining[i];
              ids[i-1]       = ids[i];
            end
            depth--;
          end
        end
        push_result(KIND_DONE, '0, 1'b1);
      end
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    // Compares one result from the block with the oldest expectation.
    task check_result(logic [2:0] kind, logic [31:0] id, logic last);
      sched_result_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        report($sformatf("result kind %0d id %0d last %0d with nothing expected",
                         kind, id, last));
        return;
      end
      want = awaited.pop_front();
      if (kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", kind, want.kind));
      if (id !== want.id)
        report($sformatf("download id %0d, expected %0d (kind %0d)", id, want.id, want.kind));
      if (last !== want.last)
        report($sformatf("last %0d, expected %0d (kind %0d)", last, want.last, want.kind));
    endtask
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        start_i         = 1'b0;
  logic        operation_i     = OP_ADD;
  logic [31:0] size_i          = '0;
  logic [15:0] seconds_i       = '0;
  logic        cfg_valid_i     = 1'b0;
  logic [31:0] cfg_bandwidth_i = '0;
  logic        busy_o;
  logic        cfg_ready_o;
  logic        result_strobe_o;
  logic [2:0]  kind_o;
  logic [31:0] download_id_o;
  logic        last_o;

  srpt_scoreboard board;
  int          idle_pct;
  int unsigned settings_used;
  int unsigned quiet_cycles = 0;

  download_srpt_scheduler_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .size_i         (size_i),
    .seconds_i      (seconds_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_bandwidth_i(cfg_bandwidth_i),
    .result_strobe_o(result_strobe_o),
    .kind_o         (kind_o),
    .download_id_o  (download_id_o),
    .last_o         (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Results cannot be held off, so every strobe is checked at the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o === 1'b1) begin
      board.check_result(kind_o, download_id_o, last_o);
    end
  end

  // The watchdog restarts whenever an item, a result or a register write moves.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || result_strobe_o || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("[%0t] watchdog: nothing moved for %0d cycles", $time, WatchdogLimit);
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Sends one item. The task is entered just after a rising edge and returns at the
  // edge that accepted the item, with start_i still high. The caller must, in that
  // same step, either present the next item or lower start_i. While the sender idles
  // the fields carry junk, which the block must ignore since start_i is low.
  task automatic send_item(logic op, logic [31:0] size, logic [15:0] seconds);
    while ($urandom_range(99) < idle_pct) begin
      start_i     <= 1'b0;
      operation_i <= 1'($urandom_range(1));
      size_i      <= $urandom;
      seconds_i   <= 16'($urandom);
      @(posedge clk_i);
    end
    start_i     <= 1'b1;
    operation_i <= op;
    size_i      <= size;
    seconds_i   <= seconds;
    do @(posedge clk_i); while (busy_o);
    board.note_item(op, size, seconds);
  endtask

  // Waits for every expected result and a few quiet cycles, so that the block is
  // idle before the next register write or the end of the run.
  task automatic wait_idle(int cycles);
    start_i <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (cycles) @(posedge clk_i);
  endtask

  // Writes the bandwidth register once the block has gone idle.
  task automatic write_bandwidth(logic [31:0] value);
    wait_idle(SettleCycles);
    cfg_valid_i     <= 1'b1;
    cfg_bandwidth_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.bandwidth = value;
    settings_used++;
    cfg_valid_i     <= 1'b0;
  endtask

  // Random traffic shaped around the current bandwidth: sizes are mostly a few
  // seconds' worth of grant, so that advances complete transfers, the queue both
  // fills and drains, and a slice of the items are zero sizes, full range sizes,
  // repeated sizes that tie, and long advances.
  task automatic random_traffic(int count);
    logic [31:0] cap;
    logic [31:0] size;
    logic [15:0] seconds;
    logic        op;
    int          roll;
    for (int n = 0; n < count; n++) begin
      if (board.bandwidth == '0) cap = 32'd4096;
      else if (board.bandwidth > 32'h3FFF_FFFF) cap = 32'hFFFF_FFFF;
      else cap = board.bandwidth << 2;
      op = ($urandom_range(99) < ((board.depth >= QueueDepth) ? 30 : 60)) ? OP_ADD : OP_ADVANCE;
      roll = $urandom_range(99);
      if (roll < 6) size = '0;
      else if (roll < 12) size = $urandom;
      else if (roll < 30) size = $urandom_range(3, 1) * ((cap >> 2) + 1);
      else size = $urandom_range(cap, 1);
      roll = $urandom_range(99);
      if (roll < 10) seconds = '0;
      else if (roll < 70) seconds = 16'($urandom_range(4, 1));
      else if (roll < 85) seconds = 16'($urandom_range(40, 5));
      else seconds = 16'($urandom_range(65535));
      send_item(op, size, seconds);
    end
  endtask

  initial begin
    board         = new();
    idle_pct      = 21;
    settings_used = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, first at the reset bandwidth of 1024 bytes per second.
    // An advance on an empty queue gives only the done result.
    send_item(OP_ADVANCE, $urandom, 16'd5);
    // A zero size is turned away but still takes an id.
    send_item(OP_ADD, 32'd0, 16'($urandom));
    send_item(OP_ADD, 32'd1, 16'($urandom));
    send_item(OP_ADD, 32'hFFFF_FFFF, 16'($urandom));
    // Two equal sizes: the newer one must sit ahead of the older.
    send_item(OP_ADD, 32'd1000, 16'($urandom));
    send_item(OP_ADD, 32'd1000, 16'($urandom));
    send_item(OP_ADD, 32'd2048, 16'($urandom));
    // Zero seconds grants nothing.
    send_item(OP_ADVANCE, $urandom, 16'd0);
    // One second of 1024 bytes: two heads complete and the third is only reduced.
    send_item(OP_ADVANCE, $urandom, 16'd1);
    // Fill the queue with small sizes that tie often, then hit the full case.
    while (board.depth < QueueDepth) begin
      send_item(OP_ADD, $urandom_range(8, 1) * 32'd100, 16'($urandom));
    end
    send_item(OP_ADD, 32'd5, 16'($urandom));
    // A zero size on a full queue is reported as empty, not full.
    send_item(OP_ADD, 32'd0, 16'($urandom));
    // Zero bandwidth grants nothing, however long the advance.
    write_bandwidth(32'd0);
    send_item(OP_ADVANCE, $urandom, 16'hFFFF);
    // The largest grant drains the full queue: sixteen completions and the done.
    write_bandwidth(32'hFFFF_FFFF);
    send_item(OP_ADVANCE, $urandom, 16'hFFFF);

    // Random part in three idling regimes, two bandwidth settings in each.
    write_bandwidth(BandwidthReset);
    random_traffic(ItemsPerLeg);
    write_bandwidth(32'd1);
    random_traffic(ItemsPerLeg);

    idle_pct = 84;
    write_bandwidth(32'hFFFF_FFFF);
    random_traffic(ItemsPerLeg);
    write_bandwidth($urandom);
    random_traffic(ItemsPerLeg);

    idle_pct = 0;
    write_bandwidth($urandom_range(5000, 1));
    random_traffic(ItemsPerLeg);
    write_bandwidth(32'h8000_0000);
    random_traffic(ItemsPerLeg);

    wait_idle(DrainCycles);
    if (board.awaited.size() != 0) begin
      board.report($sformatf("%0d results never arrived", board.awaited.size()));
    end

    $display("Covered %0d items and %0d results over %0d bandwidth settings.",
             board.items, board.results_seen, settings_used);
    $display("Seen %0d completions, %0d full rejects, %0d zero size rejects, %0d mismatches.",
             board.completions, board.full_rejects, board.empty_rejects, board.mismatches);
    if (board.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
